### design/psc_pkg.sv
// Shared types, state encoding and remainder step for the packet sequence checker.
package psc_pkg;

    localparam int unsigned SeqW      = 16;
    localparam int unsigned IdW       = 4;
    localparam int unsigned CountW    = 5;
    localparam int unsigned TotalW    = 32;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [CountW-1:0] CountReset    = 5'd16;
    localparam logic [CountW-1:0] CountMax      = 5'd16;
    localparam logic [SeqW-1:0]   RunLimitReset = 16'd100;
    localparam logic [SeqW-1:0]   SeqMax        = 16'hFFFF;
    localparam logic [TotalW-1:0] TotalMax      = 32'hFFFF_FFFF;

    localparam logic [CfgIndexW-1:0] CfgSourceCount = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgRunLimit    = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_HI,
        S_DIV_LO
    } t_state;

    typedef struct packed {
        logic capture;
        logic div_hi;
        logic commit;
    } t_dp_cmd;

    // One restoring remainder step: shift in a dividend bit, subtract if it fits.
    function automatic logic [CountW-1:0] rem_step(
        input logic [CountW-1:0] rem,
        input logic              dividend_bit,
        input logic [CountW-1:0] divisor
    );
        logic [CountW-1:0] shifted;
        shifted = {rem[CountW-2:0], dividend_bit};
        if (shifted >= divisor) begin
            rem_step = shifted - divisor;
        end else begin
            rem_step = shifted;
        end
    endfunction

endpackage

### design/psc_ctrl.sv
// Controller state machine for the packet sequence checker.
module psc_ctrl
    import psc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DIV_HI;
            S_DIV_HI: n_state = S_DIV_LO;
            S_DIV_LO: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DIV_HI: o_cmd.div_hi = 1'b1;
            S_DIV_LO: o_cmd.commit = out_free;
            default: o_cmd = '0;
        endcase
        n_out_valid = o_cmd.commit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/psc_datapath.sv
// Datapath: configuration, checker state, remainder unit and result registers.
module psc_datapath
    import psc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    input  logic                 i_req_type,
    input  logic [TotalW-1:0]    i_status_word,
    output logic                 o_source_order_error,
    output logic                 o_sequence_error,
    output logic [TotalW-1:0]    o_source_error_total,
    output logic [TotalW-1:0]    o_sequence_error_total,
    output logic [SeqW-1:0]      o_error_run,
    output logic                 o_terminate
);

    // configuration
    logic [CountW-1:0] r_source_count;
    logic [SeqW-1:0]   r_run_limit;
    logic [CountW-1:0] eff_count;

    // captured item
    logic              r_req;
    logic [SeqW-1:0]   r_seq;
    logic [IdW-1:0]    r_id;
    logic [CountW-1:0] r_dividend;
    logic [CountW-1:0] r_rem;

    // checker state
    logic              r_source_seen, n_source_seen;
    logic [IdW-1:0]    r_expected, n_expected;
    logic              r_sequence_seen, n_sequence_seen;
    logic [SeqW-1:0]   r_last_seq, n_last_seq;
    logic [TotalW-1:0] r_src_errors, n_src_errors;
    logic [TotalW-1:0] r_seq_errors, n_seq_errors;
    logic [SeqW-1:0]   r_run, n_run;
    logic              r_stop, n_stop;
    logic              src_err, seq_err;

    logic [CountW-1:0] rem_hi, rem_lo;

    always_comb begin
        priority if (r_source_count == '0) begin
            eff_count = CountW'(1);
        end else if (r_source_count > CountMax) begin
            eff_count = CountMax;
        end else begin
            eff_count = r_source_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_count <= CountReset;
            r_run_limit    <= RunLimitReset;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CfgSourceCount) r_source_count <= i_cfg_data[CountW-1:0];
            if (i_cfg_index == CfgRunLimit)    r_run_limit    <= i_cfg_data;
        end
    end

    // Remainder of (id + 1) by the source count: bits 4..2 first, then 1..0.
    always_comb begin
        rem_hi = '0;
        for (int b = CountW - 1; b >= 2; b--) begin
            rem_hi = rem_step(rem_hi, r_dividend[b], eff_count);
        end
        rem_lo = r_rem;
        for (int b = 1; b >= 0; b--) begin
            rem_lo = rem_step(rem_lo, r_dividend[b], eff_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req      <= i_req_type;
            r_seq      <= i_status_word[31:16];
            r_id       <= i_status_word[5:2];
            r_dividend <= {1'b0, i_status_word[5:2]} + CountW'(1);
        end
        if (i_cmd.div_hi) r_rem <= rem_hi;
    end

    always_comb begin
        n_source_seen   = r_source_seen;
        n_expected      = r_expected;
        n_sequence_seen = r_sequence_seen;
        n_last_seq      = r_last_seq;
        n_src_errors    = r_src_errors;
        n_seq_errors    = r_seq_errors;
        n_run           = r_run;
        n_stop          = r_stop;
        src_err         = 1'b0;
        seq_err         = 1'b0;
        if (r_req) begin
            n_source_seen   = 1'b0;
            n_sequence_seen = 1'b0;
        end else begin
            if (r_source_seen && (r_expected != r_id)) begin
                src_err = 1'b1;
                if (r_src_errors != TotalMax) n_src_errors = r_src_errors + TotalW'(1);
            end
            n_expected    = rem_lo[IdW-1:0];
            n_source_seen = 1'b1;
            if (r_sequence_seen) begin
                if (({1'b0, r_last_seq} + 17'd1 != {1'b0, r_seq}) && (r_last_seq != SeqMax)) begin
                    seq_err = 1'b1;
                    if (r_run != SeqMax)        n_run = r_run + SeqW'(1);
                    if (r_seq_errors != TotalMax) n_seq_errors = r_seq_errors + TotalW'(1);
                end else begin
                    n_run = '0;
                end
            end
            n_last_seq      = r_seq;
            n_sequence_seen = 1'b1;
            if (n_run > r_run_limit) n_stop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_seen          <= 1'b0;
            r_expected             <= '0;
            r_sequence_seen        <= 1'b0;
            r_last_seq             <= '0;
            r_src_errors           <= '0;
            r_seq_errors           <= '0;
            r_run                  <= '0;
            r_stop                 <= 1'b0;
            o_source_order_error   <= 1'b0;
            o_sequence_error       <= 1'b0;
            o_source_error_total   <= '0;
            o_sequence_error_total <= '0;
            o_error_run            <= '0;
            o_terminate            <= 1'b0;
        end else if (i_cmd.commit) begin
            r_source_seen          <= n_source_seen;
            r_expected             <= n_expected;
            r_sequence_seen        <= n_sequence_seen;
            r_last_seq             <= n_last_seq;
            r_src_errors           <= n_src_errors;
            r_seq_errors           <= n_seq_errors;
            r_run                  <= n_run;
            r_stop                 <= n_stop;
            o_source_order_error   <= src_err;
            o_sequence_error       <= seq_err;
            o_source_error_total   <= n_src_errors;
            o_sequence_error_total <= n_seq_errors;
            o_error_run            <= n_run;
            o_terminate            <= n_stop;
        end
    end

endmodule

### design/packet_sequence_checker.sv
// Top level of the packet sequence checker: controller, datapath and checks.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) moves one item: a request type
//   (0 check, 1 resync) and a 32-bit packet status word. Output channel
//   (o_out_valid / i_out_ready) returns exactly one result item per input
//   item: the two error flags, both saturating error totals, the current
//   run of consecutive sequence errors and the sticky terminate flag.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes index 0
//   source_count and index 1 run_limit; write only while the block is idle.
// Timing:
//   An accepted item passes S_DIV_HI, which takes the upper three dividend
//   bits of (id + 1) mod source_count, then S_DIV_LO, which takes the lower
//   two and commits the state. No new item is taken before that commit.
//   Input is taken while a result waits; when the receiver stalls, hold the
//   finished item in the last step until the output register frees up.
// Reset:
//   Synchronous, active low. Clears the checker state and counters, returns
//   source_count to 16 and run_limit to 100, and drops any pending result.
module packet_sequence_checker
    import psc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [TotalW-1:0]    i_status_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_source_order_error,
    output logic                 o_sequence_error,
    output logic [TotalW-1:0]    o_source_error_total,
    output logic [TotalW-1:0]    o_sequence_error_total,
    output logic [SeqW-1:0]      o_error_run,
    output logic                 o_terminate,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    t_dp_cmd cmd;

    // Config writes are registered directly, so the port never pushes back.
    assign o_cfg_ready = 1'b1;

    psc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    psc_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .i_cfg_we               (i_cfg_valid && o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_req_type             (i_req_type),
        .i_status_word          (i_status_word),
        .o_source_order_error   (o_source_order_error),
        .o_sequence_error       (o_sequence_error),
        .o_source_error_total   (o_source_error_total),
        .o_sequence_error_total (o_sequence_error_total),
        .o_error_run            (o_error_run),
        .o_terminate            (o_terminate)
    );

`ifndef SYNTH
    // One item at a time: an accepted item blocks the next until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    // Terminate never clears once set.
    a_terminate_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_terminate |=> o_terminate)
        else $error("terminate flag cleared");

    // A reported sequence error always leaves a nonzero run and total.
    a_seq_err_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sequence_error) |->
            (o_error_run != '0) && (o_sequence_error_total != '0))
        else $error("sequence error not counted");

    // A reported source order error always leaves a nonzero total.
    a_src_err_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_source_order_error) |-> (o_source_error_total != '0))
        else $error("source order error not counted");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for packet_sequence_checker: predictor, scoreboard and stimulus.
module tb;
    import psc_pkg::*;

    localparam logic ReqCheck  = 1'b0;
    localparam logic ReqResync = 1'b1;

    localparam int unsigned SeqLsb        = 16;
    localparam int unsigned IdLsb         = 2;
    localparam int unsigned ResetCycles   = 5;
    localparam int unsigned DrainCycles   = 8;
    localparam int unsigned WatchdogLimit = 5000;
    localparam int unsigned RandomPhases  = 8;
    localparam int unsigned PhaseItems    = 225;
    localparam int unsigned RunSweepItems = 200;

    typedef enum logic [1:0] {
        IdleNone,
        IdleSender,
        IdleReceiver,
        IdleBoth
    } t_idle_mode;

    typedef struct packed {
        logic              source_order_error;
        logic              sequence_error;
        logic [TotalW-1:0] source_error_total;
        logic [TotalW-1:0] sequence_error_total;
        logic [SeqW-1:0]   error_run;
        logic              terminate;
    } t_status_result;

    // Predicts one result per item and compares it with what the block returns.
    class status_scoreboard;
        logic [CountW-1:0] source_count;
        logic [SeqW-1:0]   run_limit;
        bit                source_seen;
        bit                sequence_seen;
        bit                stop_flag;
        logic [IdW-1:0]    next_source;
        logic [SeqW-1:0]   last_sequence;
        logic [SeqW-1:0]   run_length;
        logic [SeqW-1:0]   longest_run;
        logic [TotalW-1:0] source_total;
        logic [TotalW-1:0] sequence_total;
        t_status_result    outstanding_q[$];
        int unsigned       checked;
        int unsigned       mismatches;

        function new();
            source_count   = CountReset;
            run_limit      = RunLimitReset;
            source_seen    = 1'b0;
            sequence_seen  = 1'b0;
            stop_flag      = 1'b0;
            next_source    = '0;
            last_sequence  = '0;
            run_length     = '0;
            longest_run    = '0;
            source_total   = '0;
            sequence_total = '0;
            checked        = 0;
            mismatches     = 0;
        endfunction

        function void set_register(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
            if (index == CfgSourceCount) begin
                source_count = data[CountW-1:0];
            end else if (index == CfgRunLimit) begin
                run_limit = data[SeqW-1:0];
            end
        endfunction

        // Note an accepted item: update the checker state and queue its result.
        function void note_item(logic req, logic [TotalW-1:0] word);
            t_status_result   r;
            logic [SeqW-1:0]  seq;
            logic [IdW-1:0]   id;
            int unsigned      cnt;
            int unsigned      modulus;
            int unsigned      nxt;
            r = '0;
            if (req == ReqResync) begin
                source_seen   = 1'b0;
                sequence_seen = 1'b0;
            end else begin
                seq = word[SeqLsb +: SeqW];
                id  = word[IdLsb +: IdW];
                cnt = source_count;
                // zero acts as one source, anything above the maximum as the maximum
                modulus = (cnt == 0) ? 1 : ((cnt > CountMax) ? CountMax : cnt);
                if (source_seen && next_source != id) begin
                    r.source_order_error = 1'b1;
                    if (source_total != TotalMax) source_total++;
                end
                nxt         = (int'(id) + 1) % modulus;
                next_source = nxt[IdW-1:0];
                source_seen = 1'b1;
                if (sequence_seen) begin
                    // any number is in step after the top value
                    if (last_sequence != SeqMax && last_sequence + 16'd1 != seq) begin
                        r.sequence_error = 1'b1;
                        if (run_length != SeqMax) run_length++;
                        if (sequence_total != TotalMax) sequence_total++;
                    end else begin
                        run_length = '0;
                    end
                end
                last_sequence = seq;
                sequence_seen = 1'b1;
                if (run_length > run_limit) stop_flag = 1'b1;
                if (run_length > longest_run) longest_run = run_length;
            end
            r.source_error_total   = source_total;
            r.sequence_error_total = sequence_total;
            r.error_run            = run_length;
            r.terminate            = stop_flag;
            outstanding_q.push_back(r);
        endfunction

        task report(string what, logic [TotalW-1:0] got, logic [TotalW-1:0] want);
            $display("ERROR result %0d, %s: got 0x%0h, expected 0x%0h",
                     checked, what, got, want);
            mismatches++;
        endtask

        task check_result(t_status_result got);
            t_status_result want;
            if (outstanding_q.size() == 0) begin
                report("result with no item outstanding", '0, '0);
                return;
            end
            want = outstanding_q.pop_front();
            checked++;
            if (got.source_order_error !== want.source_order_error)
                report("source_order_error", got.source_order_error, want.source_order_error);
            if (got.sequence_error !== want.sequence_error)
                report("sequence_error", got.sequence_error, want.sequence_error);
            if (got.source_error_total !== want.source_error_total)
                report("source_error_total", got.source_error_total, want.source_error_total);
            if (got.sequence_error_total !== want.sequence_error_total)
                report("sequence_error_total", got.sequence_error_total,
                       want.sequence_error_total);
            if (got.error_run !== want.error_run)
                report("error_run", got.error_run, want.error_run);
            if (got.terminate !== want.terminate)
                report("terminate", got.terminate, want.terminate);
        endtask
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 i_req_type    = 1'b0;
    logic [TotalW-1:0]    i_status_word = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CfgIndexW-1:0] i_cfg_index   = '0;
    logic [CfgDataW-1:0]  i_cfg_data    = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_source_order_error;
    logic                 o_sequence_error;
    logic [TotalW-1:0]    o_source_error_total;
    logic [TotalW-1:0]    o_sequence_error_total;
    logic [SeqW-1:0]      o_error_run;
    logic                 o_terminate;
    logic                 o_cfg_ready;

    packet_sequence_checker dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_req_type             (i_req_type),
        .i_status_word          (i_status_word),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_source_order_error   (o_source_order_error),
        .o_sequence_error       (o_sequence_error),
        .o_source_error_total   (o_source_error_total),
        .o_sequence_error_total (o_sequence_error_total),
        .o_error_run            (o_error_run),
        .o_terminate            (o_terminate),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    status_scoreboard sb;
    t_status_result   seen_result;
    int unsigned      src_idle_pct  = 0;
    int unsigned      rcv_stall_pct = 0;
    int unsigned      quiet_cycles  = 0;
    int unsigned      items_sent    = 0;
    int unsigned      resyncs_sent  = 0;
    int unsigned      settings_used = 1;
    int unsigned      stim_modulus  = 16;
    int unsigned      burst_left    = 0;
    logic [SeqW-1:0]  stim_last_seq = '0;
    logic [IdW-1:0]   stim_next_id  = '0;

    logic [CountW-1:0] phase_counts [RandomPhases] =
        '{5'd16, 5'd5, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd16};
    logic [SeqW-1:0]   phase_limits [RandomPhases] =
        '{16'd100, 16'd1, 16'd0, 16'hFFFF, 16'd7, 16'd40, 16'd3, 16'd100};

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // Watch all three channels at each edge; results first, then new items.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen_result.source_order_error   = o_source_order_error;
                seen_result.sequence_error       = o_sequence_error;
                seen_result.source_error_total   = o_source_error_total;
                seen_result.sequence_error_total = o_sequence_error_total;
                seen_result.error_run            = o_error_run;
                seen_result.terminate            = o_terminate;
                sb.check_result(seen_result);
            end
            if (i_in_valid && o_in_ready) sb.note_item(i_req_type, i_status_word);
            if (i_cfg_valid && o_cfg_ready) sb.set_register(i_cfg_index, i_cfg_data);
        end
    end

    // No handshake on any channel for this long means the block has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.outstanding_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic set_idling(t_idle_mode mode);
        src_idle_pct  = (mode == IdleSender)   ? 83 : ((mode == IdleBoth) ? 11 : 0);
        rcv_stall_pct = (mode == IdleReceiver) ? 83 : ((mode == IdleBoth) ? 11 : 0);
    endtask

    // Hold valid and payload until the item is taken; valid stays up afterwards.
    task automatic send_item(logic req, logic [TotalW-1:0] word);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_status_word <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (req == ReqResync) resyncs_sent++;
    endtask

    task automatic send_check(logic [SeqW-1:0] seq, logic [IdW-1:0] id,
                              logic [TotalW-1:0] fill);
        logic [TotalW-1:0] word;
        int unsigned       nid;
        word                   = fill;
        word[SeqLsb +: SeqW]   = seq;
        word[IdLsb +: IdW]     = id;
        nid                    = (int'(id) + 1) % stim_modulus;
        stim_last_seq          = seq;
        stim_next_id           = nid[IdW-1:0];
        send_item(ReqCheck, word);
    endtask

    // Mostly in-step packets; gaps, error bursts, stray sources and resyncs mixed in.
    task automatic send_random();
        logic [SeqW-1:0]   seq;
        logic [IdW-1:0]    id;
        logic [TotalW-1:0] rnd;
        int unsigned       pick;
        pick = $urandom_range(99);
        rnd  = $urandom();
        seq  = stim_last_seq + 16'd1;
        id   = stim_next_id;
        if (burst_left == 0 && pick < 4) begin
            send_item(ReqResync, rnd);
        end else begin
            if (burst_left > 0) begin
                burst_left--;
                seq = stim_last_seq + 16'd2;
            end else if (pick < 7) begin
                burst_left = $urandom_range(120, 1);
                seq = stim_last_seq + 16'd2;
            end else if (pick < 15) begin
                case ($urandom_range(3))
                    0: begin
                        seq = SeqMax;
                    end
                    1: begin
                        seq = SeqMax - 16'd1;
                    end
                    2: begin
                        seq = '0;
                    end
                    default: begin
                        seq = rnd[SeqLsb +: SeqW];
                    end
                endcase
            end else if (pick < 23) begin
                id = rnd[IdW-1:0];
            end else if (pick < 28) begin
                seq = rnd[SeqLsb +: SeqW];
                id  = rnd[IdW-1:0];
            end
            send_check(seq, id, $urandom());
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Drain, then write both registers back to back.
    task automatic set_config(logic [CfgDataW-1:0] count_data,
                              logic [CfgDataW-1:0] limit_data);
        int unsigned c;
        wait_idle();
        write_reg(CfgSourceCount, count_data);
        write_reg(CfgRunLimit, limit_data);
        i_cfg_valid <= 1'b0;
        c = count_data[CountW-1:0];
        stim_modulus = (c == 0) ? 1 : ((c > CountMax) ? CountMax : c);
        settings_used++;
    endtask

    initial begin
        logic [CfgDataW-1:0] count_data;
        logic [CfgDataW-1:0] limit_data;
        sb = new();
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings first (16 sources, run limit 100).
        set_idling(IdleBoth);
        send_check(16'h0000, 4'd0,  '0);   // first packet, nothing to compare
        send_check(16'h0001, 4'd1,  '0);
        send_check(16'h0002, 4'd5,  '0);   // source out of turn
        send_check(16'h0009, 4'd6,  '0);   // sequence gap
        send_check(16'h000A, 4'd7,  '0);   // back in step, run clears
        send_check(16'hFFFF, 4'd15, '1);   // all ones: gap and stray source
        send_check(16'h1234, 4'd0,  '0);   // anything goes after the top value
        send_item(ReqResync, '1);
        send_check(16'h0007, 4'd3,  '1);   // first after resync
        send_check(16'h0008, 4'd4,  '0);
        send_check(16'hFFFE, 4'd15, '0);   // gap and stray source together
        send_check(16'hFFFF, 4'd0,  '0);
        send_check(16'h0000, 4'd1,  '0);
        send_item(ReqResync, '0);
        send_item(ReqResync, '0);          // back-to-back resync

        set_config(16'hFFE1, 16'hFFFF);    // one source, upper data bits ignored
        send_check(16'h0005, 4'd0, '0);
        send_check(16'h0006, 4'd0, '0);
        send_check(16'h0007, 4'd3, '0);
        set_config(16'h0000, 16'hFFFF);    // zero sources acts as one
        send_check(16'h0008, 4'd0, '0);
        send_check(16'h000A, 4'd2, '0);
        set_config(16'h001F, 16'hFFFF);    // above the maximum acts as 16
        send_check(16'h000B, 4'd0, '1);
        send_check(16'h000C, 4'd1, '0);

        // Drive a long error run; with the top limit terminate never sets.
        set_config(16'd16, 16'hFFFF);
        set_idling(IdleNone);
        for (int n = 0; n < RunSweepItems; n++) begin
            send_check((stim_last_seq == 16'd0) ? 16'd2 : 16'd0, stim_next_id, $urandom());
        end

        // Random phases, each under its own settings and idling pattern.
        for (int p = 0; p < RandomPhases; p++) begin
            count_data               = $urandom();
            count_data[CountW-1:0]   = phase_counts[p];
            limit_data               = phase_limits[p];
            burst_left               = 0;
            set_config(count_data, limit_data);
            set_idling(t_idle_mode'(p % 4));
            for (int n = 0; n < PhaseItems; n++) send_random();
        end

        set_idling(IdleNone);
        wait_idle();
        $display("Run covered %0d items (%0d resync) under %0d register settings;",
                 items_sent, resyncs_sent, settings_used);
        $display("%0d results checked, %0d source order and %0d sequence errors, run %0d, %0b.",
                 sb.checked, sb.source_total, sb.sequence_total, sb.longest_run,
                 sb.stop_flag);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
